### hw/rtl/rhd_pkg.sv
// Shared types, constants and size helpers for the cartridge header decoder.
// No dependencies; the decoder, decode and checker files take names from here by scope.
`timescale 1ns / 1ps

package rhd_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int CELLS        = HEADER_BYTES - 1;
  localparam int CNT_W        = $clog2(HEADER_BYTES);

  localparam logic [7:0] MAGIC_0 = 8'h4e;
  localparam logic [7:0] MAGIC_1 = 8'h45;
  localparam logic [7:0] MAGIC_2 = 8'h53;
  localparam logic [7:0] MAGIC_3 = 8'h1a;

  // byte 7 bits 3..2 select the header form
  localparam logic [7:0] FORM_MASK = 8'h0c;
  localparam logic [7:0] FORM_NES2 = 8'h08;
  // size MSB nibble that switches a ROM size to exponent form
  localparam logic [3:0] EXP_FORM  = 4'hf;

  // 0x4000 and 0x2000 byte units as shifts
  localparam logic [5:0] PRG_UNIT_SHIFT = 6'd14;
  localparam logic [5:0] CHR_UNIT_SHIFT = 6'd13;
  localparam logic [21:0] RAM_GRAIN     = 22'd64;
  localparam logic [21:0] CLASSIC_RAM   = 22'h2000;
  localparam logic [4:0]  CLASSIC_RAM_SHIFT = 5'd13;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_MAGIC   = 3'd1,
    ST_ZERO_FILL   = 3'd2,
    ST_TRAINER     = 3'd3,
    ST_PAL         = 3'd4,
    ST_NO_PRG      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    MIR_HORIZONTAL = 2'd0,
    MIR_VERTICAL   = 2'd1,
    MIR_FOUR       = 2'd2
  } mirror_e;

  typedef logic [HEADER_BYTES-1:0][7:0] hdr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] mapper_id;
    logic [3:0]  submapper_id;
    logic [1:0]  mirroring;
    logic [63:0] prg_rom_bytes;
    logic [63:0] chr_rom_bytes;
    logic [21:0] prg_ram_bytes;
    logic [21:0] prg_saved_ram_bytes;
    logic [21:0] chr_ram_bytes;
    logic [21:0] chr_saved_ram_bytes;
    logic [5:0]  flag_bits;
  } res_t;

  // NES 2.0 ROM size: linear units, or 2^E * (2M+1) saturating at 64 bits
  function automatic logic [63:0] rom_size_nes2(input logic [7:0] lo, input logic [3:0] hi,
                                                input logic [5:0] unit_shift);
    logic [66:0] wide;
    logic [63:0] lin;
    wide = 67'({lo[1:0], 1'b1}) << lo[7:2];
    lin  = 64'({hi, lo}) << unit_shift;
    if (hi == EXP_FORM) begin
      return (wide[66:64] != 3'd0) ? '1 : wide[63:0];
    end
    return lin;
  endfunction

  function automatic logic [21:0] ram_size_nes2(input logic [3:0] sh);
    return (sh == 4'd0) ? 22'd0 : (RAM_GRAIN << sh);
  endfunction

endpackage

### hw/rtl/rhd_intf.sv
// Channel interfaces of the header decoder: byte input, result output, config write.
// Depends on nothing; field widths follow the decoder's port list.
`timescale 1ns / 1ps

interface rhd_hdr_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       restart;
  modport source (output valid, header_byte, restart, input ready);
  modport sink   (input valid, header_byte, restart, output ready);
endinterface

interface rhd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] mapper_id;
  logic [3:0]  submapper_id;
  logic [1:0]  mirroring;
  logic [63:0] prg_rom_bytes;
  logic [63:0] chr_rom_bytes;
  logic [21:0] prg_ram_bytes;
  logic [21:0] prg_saved_ram_bytes;
  logic [21:0] chr_ram_bytes;
  logic [21:0] chr_saved_ram_bytes;
  logic [5:0]  flag_bits;
  modport source (output valid, status, mapper_id, submapper_id, mirroring, prg_rom_bytes,
                  chr_rom_bytes, prg_ram_bytes, prg_saved_ram_bytes, chr_ram_bytes,
                  chr_saved_ram_bytes, flag_bits, input ready);
  modport sink   (input valid, status, mapper_id, submapper_id, mirroring, prg_rom_bytes,
                  chr_rom_bytes, prg_ram_bytes, prg_saved_ram_bytes, chr_ram_bytes,
                  chr_saved_ram_bytes, flag_bits, output ready);
endinterface

interface rhd_cfg_if;
  logic valid;
  logic ready;
  logic allow_unsupported;
  modport source (output valid, allow_unsupported, input ready);
  modport sink   (input valid, allow_unsupported, output ready);
endinterface

### hw/rtl/rom_header_decoder.sv
// Top level of the cartridge header decoder: byte cell chain, decode, result register.
// Depends on rhd_pkg, the rhd_*_if interfaces, rhd_cell and rhd_decode.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------
//   hdr_i    | in  | valid / ready | header_byte[7:0], restart
//   res_o    | out | valid / ready | status, ids, mirroring, sizes, flag_bits
//   cfg_i    | in  | valid / ready | allow_unsupported
//
// One header byte is taken per cycle unless the byte side stalls; the result of a
// header is registered in the cycle after its 16th beat. The byte side stalls only
// while the result register holds an untaken result. Reset clears the byte count,
// the result valid and allow_unsupported; the cells hold no reset value. Config
// writes are always taken.
`timescale 1ns / 1ps

module rom_header_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  rhd_hdr_if.sink     hdr_i,
  rhd_res_if.source   res_o,
  rhd_cfg_if.sink     cfg_i
);

  logic                      accept, last;
  logic [rhd_pkg::CNT_W-1:0] idx, cnt_d, cnt_q;
  logic [7:0]                cell_q [rhd_pkg::CELLS];
  rhd_pkg::hdr_t             hdr;
  rhd_pkg::res_t             dec, res_q;
  logic                      out_valid_d, out_valid_q;
  logic                      allow_d, allow_q;

  assign hdr_i.ready = !out_valid_q || res_o.ready;
  assign accept      = hdr_i.valid && hdr_i.ready;
  assign cfg_i.ready = 1'b1;

  // restart forces this beat to header byte 0
  assign idx   = hdr_i.restart ? '0 : cnt_q;
  assign last  = idx == rhd_pkg::CNT_W'(rhd_pkg::HEADER_BYTES - 1);
  assign cnt_d = last ? '0 : idx + 1'b1;

  for (genvar k = 0; k < rhd_pkg::CELLS; k++) begin : g_cell
    logic [7:0] cell_d;
    if (k == 0) begin : g_head
      assign cell_d = hdr_i.header_byte;
    end else begin : g_link
      assign cell_d = cell_q[k-1];
    end
    rhd_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (accept),
      .byte_i (cell_d),
      .byte_o (cell_q[k])
    );
  end

  // the incoming beat is the last header byte; older bytes sit deeper in the chain
  always_comb begin
    hdr[rhd_pkg::HEADER_BYTES-1] = hdr_i.header_byte;
    for (int k = 0; k < rhd_pkg::CELLS; k++) begin
      hdr[rhd_pkg::CELLS-1-k] = cell_q[k];
    end
  end

  rhd_decode u_decode (
    .hdr_i   (hdr),
    .allow_i (allow_q),
    .res_o   (dec)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept && last) begin
      out_valid_d = 1'b1;
    end
    allow_d = (cfg_i.valid && cfg_i.ready) ? cfg_i.allow_unsupported : allow_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      allow_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      allow_q     <= allow_d;
      if (accept) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      res_q <= dec;
    end
  end

  assign res_o.valid               = out_valid_q;
  assign res_o.status              = res_q.status;
  assign res_o.mapper_id           = res_q.mapper_id;
  assign res_o.submapper_id        = res_q.submapper_id;
  assign res_o.mirroring           = res_q.mirroring;
  assign res_o.prg_rom_bytes       = res_q.prg_rom_bytes;
  assign res_o.chr_rom_bytes       = res_q.chr_rom_bytes;
  assign res_o.prg_ram_bytes       = res_q.prg_ram_bytes;
  assign res_o.prg_saved_ram_bytes = res_q.prg_saved_ram_bytes;
  assign res_o.chr_ram_bytes       = res_q.chr_ram_bytes;
  assign res_o.chr_saved_ram_bytes = res_q.chr_saved_ram_bytes;
  assign res_o.flag_bits           = res_q.flag_bits;

endmodule

### hw/rtl/rhd_cell.sv
// One byte cell of the header shift chain.
// Depends on nothing; the top level links the cells into a row.
`timescale 1ns / 1ps

module rhd_cell (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

### hw/rtl/rhd_decode.sv
// Field decode of a complete 16-byte header, classic or NES 2.0 form.
// Depends on rhd_pkg for the header and result types and size helpers.
`timescale 1ns / 1ps

module rhd_decode (
  input  rhd_pkg::hdr_t hdr_i,
  input  logic          allow_i,
  output rhd_pkg::res_t res_o
);

  logic        magic_ok, nes2, zero_ok, trainer, vs, pc10, pal, battery;
  logic [63:0] prg_rom;
  logic [21:0] prg_ram, prg_sav, chr_ram, chr_sav;

  always_comb begin
    magic_ok = (hdr_i[0] == rhd_pkg::MAGIC_0) && (hdr_i[1] == rhd_pkg::MAGIC_1) &&
               (hdr_i[2] == rhd_pkg::MAGIC_2) && (hdr_i[3] == rhd_pkg::MAGIC_3);
    nes2     = (hdr_i[7] & rhd_pkg::FORM_MASK) == rhd_pkg::FORM_NES2;
    zero_ok  = (hdr_i[11] | hdr_i[12] | hdr_i[13] | hdr_i[14] | hdr_i[15]) == 8'd0;
    trainer  = hdr_i[6][2];
    vs       = hdr_i[7][0];
    pc10     = hdr_i[7][1];

    res_o.mapper_id    = {(nes2 ? hdr_i[8][3:0] : 4'd0), hdr_i[7][7:4], hdr_i[6][7:4]};
    res_o.submapper_id = nes2 ? hdr_i[8][7:4] : 4'd0;

    if (hdr_i[6][3]) begin
      res_o.mirroring = rhd_pkg::MIR_FOUR;
    end else if (hdr_i[6][0]) begin
      res_o.mirroring = rhd_pkg::MIR_VERTICAL;
    end else begin
      res_o.mirroring = rhd_pkg::MIR_HORIZONTAL;
    end

    if (nes2) begin
      prg_rom = rhd_pkg::rom_size_nes2(hdr_i[4], hdr_i[9][3:0], rhd_pkg::PRG_UNIT_SHIFT);
      res_o.chr_rom_bytes = rhd_pkg::rom_size_nes2(hdr_i[5], hdr_i[9][7:4],
                                                   rhd_pkg::CHR_UNIT_SHIFT);
      prg_ram = rhd_pkg::ram_size_nes2(hdr_i[10][3:0]);
      prg_sav = rhd_pkg::ram_size_nes2(hdr_i[10][7:4]);
      chr_ram = rhd_pkg::ram_size_nes2(hdr_i[11][3:0]);
      chr_sav = rhd_pkg::ram_size_nes2(hdr_i[11][7:4]);
      pal     = hdr_i[12][1:0] == 2'b01;
    end else begin
      prg_rom = 64'(hdr_i[4]) << rhd_pkg::PRG_UNIT_SHIFT;
      res_o.chr_rom_bytes = 64'(hdr_i[5]) << rhd_pkg::CHR_UNIT_SHIFT;
      // a zero RAM count still means one 8 KiB bank
      prg_ram = (hdr_i[8] == 8'd0) ? rhd_pkg::CLASSIC_RAM
                                   : (22'(hdr_i[8]) << rhd_pkg::CLASSIC_RAM_SHIFT);
      prg_sav = hdr_i[6][1] ? prg_ram : 22'd0;
      chr_ram = (hdr_i[5] == 8'd0) ? rhd_pkg::CLASSIC_RAM : 22'd0;
      chr_sav = 22'd0;
      pal     = hdr_i[9][0];
    end

    battery = hdr_i[6][1] || (prg_sav != 22'd0) || (chr_sav != 22'd0);

    if (!magic_ok) begin
      res_o.status = rhd_pkg::ST_BAD_MAGIC;
    end else if (!nes2 && !zero_ok) begin
      res_o.status = rhd_pkg::ST_ZERO_FILL;
    end else if (trainer && !allow_i) begin
      res_o.status = rhd_pkg::ST_TRAINER;
    end else if (pal && !allow_i) begin
      res_o.status = rhd_pkg::ST_PAL;
    end else if (prg_rom == 64'd0) begin
      res_o.status = rhd_pkg::ST_NO_PRG;
    end else begin
      res_o.status = rhd_pkg::ST_OK;
    end

    res_o.prg_rom_bytes       = prg_rom;
    res_o.prg_ram_bytes       = prg_ram;
    res_o.prg_saved_ram_bytes = prg_sav;
    res_o.chr_ram_bytes       = chr_ram;
    res_o.chr_saved_ram_bytes = chr_sav;
    res_o.flag_bits           = {battery, pal, pc10, vs, trainer, nes2};
  end

endmodule

### hw/rtl/rhd_checker.sv
// Port-level checks on the header decoder's result channel, bound to the top level.
// Depends on rhd_pkg for status codes.
`timescale 1ns / 1ps

module rhd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic [3:0]  submapper_i,
  input logic [1:0]  mirroring_i,
  input logic [63:0] prg_rom_i,
  input logic [5:0]  flag_bits_i
);

  // hold a result beat until it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i))
    else $error("result beat dropped or changed while stalled");

  a_ok_has_prg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == rhd_pkg::ST_OK |-> prg_rom_i != 64'd0)
    else $error("ok status with empty program ROM");

  a_classic_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !flag_bits_i[0] |-> submapper_i == 4'd0)
    else $error("submapper set in classic header");

  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> mirroring_i != 2'd3)
    else $error("mirroring code out of range");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= rhd_pkg::ST_NO_PRG)
    else $error("status code out of range");

endmodule

bind rom_header_decoder rhd_checker u_rhd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .status_i    (res_o.status),
  .submapper_i (res_o.submapper_id),
  .mirroring_i (res_o.mirroring),
  .prg_rom_i   (res_o.prg_rom_bytes),
  .flag_bits_i (res_o.flag_bits)
);
